// ===== sv/mac_pkg.sv =====
// shared types, constants and result rules of the modem answer classifier
package mac_pkg;

  typedef enum logic [2:0] {
    RES_OK     = 3'd0,
    RES_ERROR  = 3'd1,
    RES_AT_OK  = 3'd2,
    RES_MORE   = 3'd3,
    RES_OTHER  = 3'd4,
    RES_WAIT   = 3'd5,
    RES_REG    = 3'd6,
    RES_REGING = 3'd7
  } result_e;

  typedef enum logic [3:0] {
    CMD_AT     = 4'd0,
    CMD_PIN    = 4'd1,
    CMD_FMT    = 4'd2,
    CMD_NOTIFY = 4'd3,
    CMD_SEND   = 4'd4,
    CMD_SEND2  = 4'd5,
    CMD_DELETE = 4'd6,
    CMD_CREG   = 4'd7,
    CMD_CSCA   = 4'd8,
    CMD_ECHO   = 4'd9
  } cmd_e;

  localparam logic [1:0] STATUS_OTHER  = 2'd0;
  localparam logic [1:0] STATUS_REG    = 2'd1;
  localparam logic [1:0] STATUS_REGING = 2'd2;

  // summary of one word
  typedef struct packed {
    logic [1:0] status;
    logic       creg;
    logic       cmgs;
    logic       prompt;
    logic       at;
    logic       err;
    logic       ok;
  } word_info_t;

  localparam int NPAT = 7;

  // patterns: OK, ERROR, AT, "> ", ">", +CMGS:, +CREG:
  localparam logic [7:0] PAT_TEXT [NPAT][6] = '{
    '{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h00},
    '{8'h41, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3E, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h43, 8'h4D, 8'h47, 8'h53, 8'h3A},
    '{8'h2B, 8'h43, 8'h52, 8'h45, 8'h47, 8'h3A}
  };
  localparam logic [2:0] PAT_LEN [NPAT] = '{3'd2, 3'd5, 3'd2, 3'd2, 3'd1, 3'd6, 3'd6};
  localparam logic [NPAT-1:0] PAT_PREFIX = 7'b1100000;

  localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;
  localparam logic [7:0] CHAR_COMMA    = 8'h2C;
  localparam logic [7:0] CHAR_ONE      = 8'h31;
  localparam logic [7:0] CHAR_TWO      = 8'h32;
  localparam logic [7:0] CHAR_FIVE     = 8'h35;

  function automatic result_e ok_err_other(input word_info_t info);
    result_e r;
    if (info.ok) r = RES_OK;
    else if (info.err) r = RES_ERROR;
    else r = RES_OTHER;
    return r;
  endfunction

  function automatic result_e err_other(input word_info_t info);
    return info.err ? RES_ERROR : RES_OTHER;
  endfunction

endpackage

// ===== sv/modem_answer_classifier.sv =====
// modem answer classifier: word splitting, pattern matching, result register
// a byte accepted into the input register is scanned from there; the result of a final
//   byte goes to the result register, and the single scan stage between them sets the rate
// throughput: one byte per cycle while no final byte waits on a stalled result
// reset: asynchronous active low; clears pending command, per-answer state and both
//   valid flags; the block can take a byte right after reset
module modem_answer_classifier #(
  parameter int COUNT_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  // answer bytes
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] answer_byte_i,
  input  logic       answer_last_i,
  // results
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] result_code_o,
  output logic [7:0] word_total_o
);
  import mac_pkg::*;

  // registration digit scan codes
  localparam logic [2:0] SCAN_SEEK   = 3'd0;
  localparam logic [2:0] SCAN_COMMA  = 3'd1;
  localparam logic [2:0] SCAN_REG    = 3'd2;
  localparam logic [2:0] SCAN_REGING = 3'd3;
  localparam logic [2:0] SCAN_NONE   = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [2:0]            POS_MAX   = 3'd7;

  // configuration register, always ready
  logic [3:0] pending_cmd_q;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  // per-answer state
  logic                  inside_q;
  logic [COUNT_BITS-1:0] words_q, words_d;
  logic [2:0]            pos_q, pos_d;
  logic [NPAT-1:0]       cand_q, cand_d;
  logic [2:0]            scan_q, scan_d;
  word_info_t            first_q, first_d;
  word_info_t            second_q, second_d;
  word_info_t            latest_q, latest_d;

  // result register
  logic       out_valid_q;
  result_e    code_q;
  logic [7:0] total_q;

  // scan stage signals
  logic            adv;
  logic            printable, word_start, word_end;
  logic [7:0]      upper;
  logic [2:0]      pos_cur;
  logic [NPAT-1:0] cand_cur, hit;
  logic [2:0]      scan_cur;
  word_info_t      info;
  result_e         code_d;

  assign cfg_ready_o = 1'b1;

  // a non-final byte never needs the result register
  assign adv        = in_valid_q && (!last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_comb begin
    printable  = (byte_q >= CHAR_PRINT_LO) && (byte_q <= CHAR_PRINT_HI);
    upper      = ((byte_q >= CHAR_LOWER_A) && (byte_q <= CHAR_LOWER_Z)) ?
                 byte_q - CASE_OFFSET : byte_q;
    word_start = printable && !inside_q;
    word_end   = (printable && last_q) || (!printable && inside_q);

    // fresh match state at the start of a word
    pos_cur  = word_start ? 3'd0 : pos_q;
    cand_cur = word_start ? '1 : cand_q;
    scan_cur = word_start ? SCAN_SEEK : scan_q;

    // drop patterns that this character rules out
    cand_d = cand_cur;
    for (int c = 0; c < NPAT; c++) begin
      if (pos_cur < PAT_LEN[c]) begin
        if (upper != PAT_TEXT[c][pos_cur]) cand_d[c] = 1'b0;
      end else if (!PAT_PREFIX[c]) begin
        cand_d[c] = 1'b0;
      end
    end

    // status digit right after the first comma
    scan_d = scan_cur;
    case (scan_cur)
      SCAN_SEEK: begin
        if (byte_q == CHAR_COMMA) scan_d = SCAN_COMMA;
      end
      SCAN_COMMA: begin
        if (byte_q == CHAR_ONE || byte_q == CHAR_FIVE) scan_d = SCAN_REG;
        else if (byte_q == CHAR_TWO) scan_d = SCAN_REGING;
        else scan_d = SCAN_NONE;
      end
      default: scan_d = scan_cur;
    endcase

    pos_d = (pos_cur == POS_MAX) ? POS_MAX : pos_cur + 3'd1;

    // a separator leaves the match state as it was
    if (!printable) begin
      pos_d  = pos_q;
      cand_d = cand_q;
      scan_d = scan_q;
    end

    // word summary from the state after this character
    for (int c = 0; c < NPAT; c++) begin
      hit[c] = cand_d[c] && (PAT_PREFIX[c] ? (pos_d >= PAT_LEN[c]) : (pos_d == PAT_LEN[c]));
    end
    info        = '0;
    info.ok     = hit[0];
    info.err    = hit[1];
    info.at     = hit[2];
    info.prompt = hit[3] || hit[4];
    info.cmgs   = hit[5];
    info.creg   = hit[6];
    if (scan_d == SCAN_REG) info.status = STATUS_REG;
    else if (scan_d == SCAN_REGING) info.status = STATUS_REGING;
    else info.status = STATUS_OTHER;

    first_d  = first_q;
    second_d = second_q;
    latest_d = latest_q;
    words_d  = words_q;
    if (word_end) begin
      if (words_q == '0) first_d = info;
      else if (words_q == COUNT_BITS'(1)) second_d = info;
      latest_d = info;
      if (words_q != COUNT_MAX) words_d = words_q + COUNT_BITS'(1);
    end
  end

  mac_classify #(
    .COUNT_BITS (COUNT_BITS)
  ) u_classify (
    .cmd_i    (pending_cmd_q),
    .words_i  (words_d),
    .first_i  (first_d),
    .second_i (second_d),
    .latest_i (latest_d),
    .code_o   (code_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_cmd_q <= CMD_AT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pending_cmd_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= answer_byte_i;
      last_q <= answer_last_i;
    end
  end

  // per-answer state, cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      words_q  <= '0;
      pos_q    <= '0;
      cand_q   <= '1;
      scan_q   <= SCAN_SEEK;
      first_q  <= '0;
      second_q <= '0;
      latest_q <= '0;
    end else if (adv) begin
      if (last_q) begin
        inside_q <= 1'b0;
        words_q  <= '0;
        pos_q    <= '0;
        cand_q   <= '1;
        scan_q   <= SCAN_SEEK;
        first_q  <= '0;
        second_q <= '0;
        latest_q <= '0;
      end else begin
        inside_q <= printable;
        words_q  <= words_d;
        pos_q    <= pos_d;
        cand_q   <= cand_d;
        scan_q   <= scan_d;
        first_q  <= first_d;
        second_q <= second_d;
        latest_q <= latest_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      code_q  <= code_d;
      total_q <= 8'(words_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = code_q;
  assign word_total_o  = total_q;

endmodule

// ===== sv/mac_classify.sv =====
// result rule per pending command, from word count and word summaries
module mac_classify #(
  parameter int COUNT_BITS = 8
) (
  input  logic [3:0]             cmd_i,
  input  logic [COUNT_BITS-1:0]  words_i,
  input  mac_pkg::word_info_t    first_i,
  input  mac_pkg::word_info_t    second_i,
  input  mac_pkg::word_info_t    latest_i,
  output mac_pkg::result_e       code_o
);
  import mac_pkg::*;

  logic n_zero, n_one, n_two, n_below2;

  assign n_zero   = (words_i == '0);
  assign n_one    = (words_i == COUNT_BITS'(1));
  assign n_two    = (words_i == COUNT_BITS'(2));
  assign n_below2 = n_zero || n_one;

  always_comb begin
    code_o = RES_OTHER;
    case (cmd_i) inside
      CMD_AT, CMD_FMT, CMD_NOTIFY, CMD_DELETE, CMD_CSCA: begin
        if (n_zero) code_o = RES_OTHER;
        else if (n_one) code_o = ok_err_other(first_i);
        else if (n_two && first_i.at && second_i.ok) code_o = RES_AT_OK;
        else code_o = RES_MORE;
      end
      CMD_PIN, CMD_ECHO: begin
        if (n_zero) code_o = RES_OTHER;
        else code_o = ok_err_other(latest_i);
      end
      CMD_SEND: begin
        if (n_zero) code_o = RES_OTHER;
        else if (n_one) code_o = first_i.prompt ? RES_WAIT : err_other(first_i);
        else code_o = RES_MORE;
      end
      CMD_SEND2: begin
        if (n_below2) code_o = RES_OTHER;
        else if (!n_two) code_o = RES_MORE;
        else if (first_i.cmgs) code_o = ok_err_other(second_i);
        else code_o = err_other(first_i);
      end
      CMD_CREG: begin
        if (n_below2) code_o = RES_OTHER;
        else if (!n_two) code_o = RES_MORE;
        else if (first_i.creg) begin
          if (second_i.ok) begin
            if (first_i.status == STATUS_REG) code_o = RES_REG;
            else if (first_i.status == STATUS_REGING) code_o = RES_REGING;
            else code_o = RES_OTHER;
          end else begin
            code_o = err_other(second_i);
          end
        end else begin
          code_o = err_other(first_i);
        end
      end
      default: code_o = RES_OTHER;
    endcase
  end

endmodule

// ===== sv/mac_checker.sv =====
// port-level checks of the modem answer classifier and their binding
module mac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       answer_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] result_code_o,
  input logic [7:0] word_total_o
);
  import mac_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_code_o) &&
    $stable(word_total_o))
    else $error("result changed while stalled");

  // a fresh result follows a final byte accepted at the input
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && answer_last_i, 2))
    else $error("result without a final byte");

  // two-word outcomes only with exactly two words
  a_two_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o == RES_AT_OK || result_code_o == RES_REG ||
    result_code_o == RES_REGING) |-> word_total_o == 8'd2)
    else $error("two-word result with another word count");

endmodule

bind modem_answer_classifier mac_checker u_mac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .answer_last_i (answer_last_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_code_o (result_code_o),
  .word_total_o  (word_total_o)
);
